[rtl/core/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority tick scheduler: table size,
// field widths, operation codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Table geometry and stored field widths.
  localparam int SLOTS         = 4;
  localparam int TIME_BITS     = 16;
  localparam int PRIO_BITS     = 8;
  localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Operation codes of the opcode field.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  slot;
    logic [15:0] burst;
    logic [7:0]  prio;
  } pts_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  chosen_slot;
    logic        idle;
    logic [15:0] remaining;
    logic [15:0] waited;
    logic        all_done;
  } pts_out_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] run;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] wcnt;
  } pts_entry_t;

endpackage : pts_pkg

`default_nettype wire

[rtl/core/priority_tick_scheduler_core.sv]
// ----------------------------------------------------------------------------
// priority_tick_scheduler_core
// Preemptive priority scheduler over a table of task slots held in one
// synchronous memory. Loads and reads touch one entry; a tick scans every
// entry once, charging a waiting tick to each ready slot, and then rewrites
// the winner with one tick less run time and its waiting count unchanged.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------
//   in_     | input     | in_valid / in_ready  | pts_in_t  (op, slot, ...)
//   out_    | output    | out_valid / out_ready| pts_out_t (one per item)
//
// A load passes S_OUT, a read S_RD and S_OUT, a tick S_SCAN, S_FIX and S_OUT;
// the scan is bounded by the single read port of the slot memory.
// One item is in work at a time; in_ready is high only between items.
// Reset clears per-entry valid and busy bits at once; no clearing pass.
// A stalled result holds in the output register and the block waits for it.
//
`default_nettype none

module priority_tick_scheduler_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pts_pkg::pts_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pts_pkg::pts_out_t      out_data
);

  import pts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_RD,
    S_OUT
  } state_t;

  localparam logic [SLOT_IDX_BITS-1:0] LAST_IDX = SLOT_IDX_BITS'(SLOTS - 1);

  // Slot memory and its ports.
  pts_entry_t                mem [SLOTS];
  pts_entry_t                rd_data_r;
  logic                      rd_vld_r;
  logic                      rd_en;
  logic [SLOT_IDX_BITS-1:0]  rd_addr;
  logic                      wr_en;
  logic [SLOT_IDX_BITS-1:0]  wr_addr;
  pts_entry_t                wr_data;

  // Per-entry written and nonzero run time flags.
  logic [SLOTS-1:0]          vld_r;
  logic [SLOTS-1:0]          nz_r;

  // Control and working registers.
  state_t                    st_r, st_nxt;
  logic [1:0]                slot_r;
  logic                      ok_r;
  logic [SLOT_IDX_BITS-1:0]  iss_r;
  logic                      iss_done_r;
  logic                      rd_pend_r;
  logic [SLOT_IDX_BITS-1:0]  rd_idx_r;
  logic [SLOT_IDX_BITS-1:0]  best_idx_r;
  logic [PRIO_BITS-1:0]      best_prio_r;
  logic [TIME_BITS-1:0]      best_run_r;
  logic [TIME_BITS-1:0]      best_wcnt_r;
  pts_out_t                  res_r;
  logic                      out_valid_r;
  pts_out_t                  out_data_r;

  // Decoded input transfer.
  logic                      in_fire;
  logic                      in_ok;
  logic [SLOT_IDX_BITS-1:0]  in_idx;
  logic [TIME_BITS-1:0]      in_run;

  // Scan datapath.
  logic [TIME_BITS-1:0]      cur_run;
  logic [PRIO_BITS-1:0]      cur_prio;
  logic [TIME_BITS-1:0]      cur_wcnt;
  logic                      cur_rdy;
  logic                      cur_better;
  logic                      scan_last;
  logic                      found;

  assign in_ready  = (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_ok     = (32'(in_data.slot) < SLOTS);
  assign in_idx    = SLOT_IDX_BITS'(in_data.slot);
  assign in_run    = TIME_BITS'(in_data.burst);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entries never written read as zero.
  assign cur_run    = rd_vld_r ? rd_data_r.run  : '0;
  assign cur_prio   = rd_vld_r ? rd_data_r.prio : '0;
  assign cur_wcnt   = rd_vld_r ? rd_data_r.wcnt : '0;
  assign cur_rdy    = rd_pend_r && (cur_run != '0) && (cur_prio != '0);
  assign cur_better = cur_rdy && (cur_prio > best_prio_r);
  assign scan_last  = rd_pend_r && (rd_idx_r == LAST_IDX);
  assign found      = (best_prio_r != '0);

  // Memory read port: one read per slot during a scan, one for a read item.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_idx;
    if (st_r == S_SCAN) begin
      rd_en   = !iss_done_r;
      rd_addr = iss_r;
    end else if (in_fire && in_data.opcode == OP_READ && in_ok) begin
      rd_en = 1'b1;
    end
  end

  // Memory write port: load, waiting-count charge, winner write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_idx;
    wr_data = '{run: in_run, prio: PRIO_BITS'(in_data.prio), wcnt: '0};
    unique case (st_r)
      S_IDLE: begin
        wr_en = in_fire && (in_data.opcode == OP_LOAD) && in_ok;
      end
      S_SCAN: begin
        wr_en   = cur_rdy;
        wr_addr = rd_idx_r;
        wr_data = '{run: cur_run, prio: cur_prio,
                    wcnt: (cur_wcnt == '1) ? cur_wcnt : cur_wcnt + 1'b1};
      end
      S_FIX: begin
        wr_en   = found;
        wr_addr = best_idx_r;
        wr_data = '{run: best_run_r - 1'b1, prio: best_prio_r, wcnt: best_wcnt_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Synchronous memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.opcode)
            OP_TICK: st_nxt = S_SCAN;
            OP_READ: st_nxt = S_RD;
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          st_nxt = S_FIX;
        end
      end
      S_FIX:   st_nxt = S_OUT;
      S_RD:    st_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // State, flags, scan registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      vld_r       <= '0;
      nz_r        <= '0;
      rd_pend_r   <= 1'b0;
      iss_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;

      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
        nz_r[wr_addr]  <= (wr_data.run != '0);
      end

      // The output register fills when a result moves in and empties on its transfer.
      if (st_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Scan read tracking.
      rd_pend_r <= (st_r == S_SCAN) && rd_en;
      if (st_r == S_SCAN && rd_en) begin
        rd_idx_r <= iss_r;
        iss_r    <= iss_r + 1'b1;
        if (iss_r == LAST_IDX) begin
          iss_done_r <= 1'b1;
        end
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            slot_r      <= in_data.slot;
            ok_r        <= in_ok;
            iss_r       <= '0;
            iss_done_r  <= 1'b0;
            best_prio_r <= '0;
            best_idx_r  <= '0;
            best_run_r  <= '0;
            best_wcnt_r <= '0;
            if (in_data.opcode == OP_LOAD) begin
              res_r <= '{chosen_slot: in_data.slot, idle: 1'b0,
                         remaining: in_ok ? 16'(in_run) : 16'd0,
                         waited: 16'd0, all_done: 1'b0};
            end else begin
              res_r <= '0;
            end
          end
        end
        S_SCAN: begin
          // Strictly greater keeps the lowest index on a tie.
          if (cur_better) begin
            best_prio_r <= cur_prio;
            best_idx_r  <= rd_idx_r;
            best_run_r  <= cur_run;
            best_wcnt_r <= cur_wcnt;
          end
        end
        S_FIX: begin
          if (found) begin
            res_r <= '{chosen_slot: 2'(best_idx_r), idle: 1'b0,
                       remaining: 16'(best_run_r - 1'b1),
                       waited: 16'(best_wcnt_r), all_done: 1'b0};
          end else begin
            res_r <= '{chosen_slot: 2'd0, idle: 1'b1, remaining: 16'd0,
                       waited: 16'd0, all_done: 1'b0};
          end
        end
        S_RD: begin
          res_r <= '{chosen_slot: slot_r, idle: 1'b0,
                     remaining: ok_r ? 16'(cur_run) : 16'd0,
                     waited: ok_r ? 16'(cur_wcnt) : 16'd0, all_done: 1'b0};
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r <= '{chosen_slot: res_r.chosen_slot, idle: res_r.idle,
                            remaining: res_r.remaining, waited: res_r.waited,
                            all_done: ~|nz_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // A loaded slot's busy flag follows the loaded run time.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_LOAD && in_ok
    |=> nz_r[$past(in_idx)] == ($past(in_run) != '0))
    else $error("busy flag does not match loaded run time");

  // The scan never reads the entry it is writing back.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("slot memory read and write hit the same entry");

  // A winning slot always has run time left to take.
  a_winner_runs: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIX && found |-> best_run_r != '0)
    else $error("tick winner has no run time left");
`endif

endmodule : priority_tick_scheduler_core

`default_nettype wire

[tb/tb_priority_tick_scheduler_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_tick_scheduler_core
// Self-checking bench for the priority tick scheduler core. A local model of
// the slot table predicts one result for every accepted input transfer, and
// a checker compares each output transfer with the oldest prediction. The
// tests cover directed corner cases, waiting-count growth, random traffic
// under several idle and stall patterns, and a long output hold-off that
// backs the block up into its input.
// ----------------------------------------------------------------------------

module tb_priority_tick_scheduler_core;
  import pts_pkg::*;

  // The opcode field has one code that the package leaves unnamed.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_GAP        = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int TAIL_CYCLES    = 2 * (SLOTS + 4);
  localparam int PHASE_ITEMS    = 310;
  localparam int WAIT_TICKS     = 200;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  pts_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  pts_out_t out_data;

  // Idle and stall percentages of the current phase.
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  // Length of a requested receiver hold-off; cleared by the receiver.
  int hold_len      = 0;

  int error_count   = 0;
  int quiet_cycles  = 0;

  // Scheduler state as the bench sees it.
  logic [TIME_BITS-1:0] slot_run  [SLOTS];
  logic [PRIO_BITS-1:0] slot_prio [SLOTS];
  logic [TIME_BITS-1:0] slot_wait [SLOTS];

  pts_out_t pending_results [$];
  pts_out_t oldest_result;

  priority_tick_scheduler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Apply one item to the local table and return the result it causes.
  function automatic pts_out_t schedule_step(pts_in_t item);
    pts_out_t res;
    int       best;
    logic     found;
    logic     none_left;
    res   = '0;
    best  = 0;
    found = 1'b0;
    case (item.opcode)
      OP_LOAD, OP_READ: begin
        res.chosen_slot = item.slot;
        if (int'(item.slot) < SLOTS) begin
          if (item.opcode == OP_LOAD) begin
            slot_run[item.slot]  = item.burst[TIME_BITS-1:0];
            slot_prio[item.slot] = item.prio[PRIO_BITS-1:0];
            slot_wait[item.slot] = '0;
          end
          res.remaining = slot_run[item.slot];
          res.waited    = slot_wait[item.slot];
        end
      end
      OP_TICK: begin
        // Highest priority among ready slots; the lowest index wins a tie.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_run[i] != 0 && slot_prio[i] != 0 &&
              (!found || slot_prio[i] > slot_prio[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          res.idle = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (i != best && slot_run[i] != 0 && slot_prio[i] != 0 &&
                slot_wait[i] != TIME_MAX) begin
              slot_wait[i] = slot_wait[i] + 1'b1;
            end
          end
          slot_run[best]  = slot_run[best] - 1'b1;
          res.chosen_slot = best[1:0];
          res.remaining   = slot_run[best];
          res.waited      = slot_wait[best];
        end
      end
      default: begin
        res = '0;
      end
    endcase
    none_left = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_run[i] != 0) none_left = 1'b0;
    end
    res.all_done = none_left;
    return res;
  endfunction

  // Offer one item, wait for its transfer, then record its prediction.
  task automatic send_item(input pts_in_t item);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(schedule_step(item));
  endtask

  task automatic send_op(input logic [1:0] op, input logic [1:0] slot,
                         input logic [15:0] burst, input logic [7:0] prio);
    pts_in_t item;
    item.opcode = op;
    item.slot   = slot;
    item.burst  = burst;
    item.prio   = prio;
    send_item(item);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random item: mostly ticks, short bursts and few priorities so that
  // slots finish, ties occur and idle ticks show up.
  function automatic pts_in_t random_item();
    pts_in_t item;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      item.opcode = OP_TICK;
    else if (pick < 75) item.opcode = OP_LOAD;
    else if (pick < 95) item.opcode = OP_READ;
    else                item.opcode = OP_UNUSED;
    item.slot = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       item.burst = '0;
      1:       item.burst = 16'($urandom_range(0, 16'hFFFF));
      default: item.burst = 16'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       item.prio = '0;
      1:       item.prio = 8'($urandom_range(0, 8'hFF));
      default: item.prio = 8'($urandom_range(1, 4));
    endcase
    return item;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Compare every output transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("chosen_slot", 32'(oldest_result.chosen_slot),
                    32'(out_data.chosen_slot));
        check_field("idle", 32'(oldest_result.idle), 32'(out_data.idle));
        check_field("remaining", 32'(oldest_result.remaining),
                    32'(out_data.remaining));
        check_field("waited", 32'(oldest_result.waited), 32'(out_data.waited));
        check_field("all_done", 32'(oldest_result.all_done),
                    32'(out_data.all_done));
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        for (held = 0; held < hold_len; held++) @(posedge clk);
        hold_len = 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_priority_tick_scheduler_core: done, errors");
        $finish;
      end
    end
  end

  // Empty table, unready slots, ties, priority changes and the unused code.
  task automatic test_directed_cases();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    for (int s = 0; s < SLOTS; s++) send_op(OP_READ, s[1:0], 16'hFFFF, 8'hFF);
    send_op(OP_LOAD, 2'd0, 16'h0000, 8'hFF);
    send_op(OP_TICK, 2'd3, 16'hFFFF, 8'hFF);
    send_op(OP_LOAD, 2'd1, 16'h0003, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_UNUSED, 2'd3, 16'hFFFF, 8'hFF);
    send_op(OP_LOAD, 2'd2, 16'hFFFF, 8'hFF);
    send_op(OP_LOAD, 2'd3, 16'h0002, 8'hFF);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_READ, 2'd3, 16'h0000, 8'h00);
    send_op(OP_LOAD, 2'd0, 16'h0001, 8'h80);
    send_op(OP_LOAD, 2'd2, 16'h0001, 8'h01);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_READ, 2'd2, 16'h0000, 8'h00);
    send_op(OP_TICK, 2'd0, 16'h0000, 8'h00);
    send_op(OP_UNUSED, 2'd0, 16'h0000, 8'h00);
    drain_results();
  endtask

  // One slot runs long while another waits and builds up its waiting count.
  task automatic test_wait_growth();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_op(OP_LOAD, 2'd0, 16'hFFFF, 8'd200);
    send_op(OP_LOAD, 2'd1, 16'd5, 8'd100);
    send_op(OP_LOAD, 2'd2, 16'd0, 8'd0);
    send_op(OP_LOAD, 2'd3, 16'd0, 8'd0);
    repeat (WAIT_TICKS) send_op(OP_TICK, 2'd0, 16'd0, 8'd0);
    send_op(OP_READ, 2'd1, 16'd0, 8'd0);
    send_op(OP_LOAD, 2'd0, 16'd3, 8'd200);
    repeat (3) send_op(OP_TICK, 2'd0, 16'd0, 8'd0);
    send_op(OP_READ, 2'd1, 16'd0, 8'd0);
    repeat (6) send_op(OP_TICK, 2'd0, 16'd0, 8'd0);
    drain_results();
  endtask

  // Random traffic with the given sender idle and receiver stall rates.
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_item(random_item());
    drain_results();
  endtask

  // The receiver holds off while the sender keeps offering transfers.
  task automatic test_output_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_len      = HOLD_OFF_LEN;
    repeat (16) send_item(random_item());
    drain_results();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_run[s]  = '0;
      slot_prio[s] = '0;
      slot_wait[s] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_wait_growth();
    test_random_phase(0, 0);
    test_random_phase(79, 0);
    test_random_phase(0, 79);
    test_random_phase(9, 9);
    test_output_backpressure();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_priority_tick_scheduler_core: done, clean");
    end else begin
      $display("tb_priority_tick_scheduler_core: done, errors");
    end
    $finish;
  end

endmodule
